// ===== rtl/core/kmcs_pkg.sv =====
// Package for the key matrix column scanner.
// Holds the matrix geometry, widths, phase codes and the struct types.
// Used by the channel interfaces, kmcs_step and key_matrix_column_scanner.
package kmcs_pkg;

  localparam int ROWS     = 6;
  localparam int COLUMNS  = 8;
  localparam int MATRIX_W = 48;
  localparam int TIMER_W  = 16;
  localparam int SELECT_W = 3;
  localparam int ROW_W    = 6;
  localparam int COUNT_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [TIMER_W-1:0] SETTLE_RESET = 16'd5000;
  localparam logic [ROW_W-1:0]   GROUP1_MASK  = 6'h07;
  localparam logic [ROW_W-1:0]   GROUP2_MASK  = 6'h38;

  typedef enum logic [4:0] {
    PH_DRIVE_WAIT    = 5'b00001,
    PH_SAMPLE        = 5'b00010,
    PH_WAIT_COL_HIGH = 5'b00100,
    PH_WAIT_GROUP1   = 5'b01000,
    PH_WAIT_GROUP2   = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [COUNT_W-1:0]    column;
    logic [TIMER_W-1:0]    timer;
    logic [MATRIX_W-1:0]   work;
    logic [MATRIX_W-1:0]   reported;
  } scan_state_t;

  typedef struct packed {
    logic             column_level;
    logic [ROW_W-1:0] row_levels;
  } item_t;

  typedef struct packed {
    logic [SELECT_W-1:0] column_select;
    logic                column_drive_low;
    logic                scan_done;
    logic                matrix_changed;
    logic [MATRIX_W-1:0] key_matrix;
  } result_t;

endpackage

// ===== rtl/core/kmcs_item_if.sv =====
// Request channel carrying one timer tick with the sampled pin levels.
// Depends on kmcs_pkg for the field widths.
interface kmcs_item_if;
  import kmcs_pkg::*;

  logic             valid;
  logic             ready;
  logic             column_level;
  logic [ROW_W-1:0] row_levels;

  modport source(output valid, output column_level, output row_levels, input ready);
  modport sink(input valid, input column_level, input row_levels, output ready);
endinterface

// ===== rtl/core/kmcs_result_if.sv =====
// Result channel carrying the column drive state and the reported matrix.
// Depends on kmcs_pkg for the field widths.
interface kmcs_result_if;
  import kmcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [SELECT_W-1:0] column_select;
  logic                column_drive_low;
  logic                scan_done;
  logic                matrix_changed;
  logic [MATRIX_W-1:0] key_matrix;

  modport source(output valid, output column_select, output column_drive_low,
                 output scan_done, output matrix_changed, output key_matrix,
                 input ready);
  modport sink(input valid, input column_select, input column_drive_low,
               input scan_done, input matrix_changed, input key_matrix,
               output ready);
endinterface

// ===== rtl/core/kmcs_step.sv =====
// Next-state and result logic of the scanner for one tick.
// Depends on kmcs_pkg for the state, item and result types.
module kmcs_step (
  input  kmcs_pkg::scan_state_t         state,
  input  kmcs_pkg::item_t               item,
  input  logic [kmcs_pkg::TIMER_W-1:0]  settle_timeout,
  output kmcs_pkg::scan_state_t         state_next,
  output kmcs_pkg::result_t             result
);
  import kmcs_pkg::*;

  logic [MATRIX_W-1:0] sampled;
  logic [TIMER_W-1:0]  timer_inc;
  logic                timeout_hit;
  logic [COUNT_W:0]    column_inc;
  logic                last_column;

  assign timer_inc   = state.timer + 1'b1;
  assign timeout_hit = (state.timer >= settle_timeout);
  assign column_inc  = {1'b0, state.column} + 1'b1;
  assign last_column = (column_inc >= (COUNT_W + 1)'(COLUMNS));

  // A low row means the key in the selected column is pressed.
  always_comb begin
    sampled = state.work;
    for (int b = 0; b < MATRIX_W; b++) begin
      if ((b / COLUMNS) < ROWS && COUNT_W'(b % COLUMNS) == state.column) begin
        sampled[b] = ~item.row_levels[b / COLUMNS];
      end
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    case (state.phase)
      PH_DRIVE_WAIT: begin
        if (!item.column_level || timeout_hit) begin
          state_next.timer = '0;
          state_next.phase = PH_SAMPLE;
        end else begin
          state_next.timer = timer_inc;
        end
      end
      PH_SAMPLE: begin
        state_next.work  = sampled;
        state_next.timer = '0;
        state_next.phase = PH_WAIT_COL_HIGH;
      end
      PH_WAIT_COL_HIGH: begin
        if (item.column_level || timeout_hit) begin
          state_next.timer = '0;
          state_next.phase = PH_WAIT_GROUP1;
        end else begin
          state_next.timer = timer_inc;
        end
      end
      PH_WAIT_GROUP1: begin
        if ((item.row_levels & GROUP1_MASK) == GROUP1_MASK || timeout_hit) begin
          state_next.timer = '0;
          state_next.phase = PH_WAIT_GROUP2;
        end else begin
          state_next.timer = timer_inc;
        end
      end
      PH_WAIT_GROUP2: begin
        if ((item.row_levels & GROUP2_MASK) == GROUP2_MASK || timeout_hit) begin
          state_next.timer = '0;
          state_next.phase = PH_DRIVE_WAIT;
          if (last_column) begin
            state_next.column = '0;
            result.scan_done  = 1'b1;
            if (state.work != state.reported) begin
              state_next.reported   = state.work;
              result.matrix_changed = 1'b1;
            end
          end else begin
            state_next.column = column_inc[COUNT_W-1:0];
          end
        end else begin
          state_next.timer = timer_inc;
        end
      end
      default: begin
        state_next.phase = PH_DRIVE_WAIT;
        state_next.timer = '0;
      end
    endcase
    result.column_select    = SELECT_W'(state_next.column);
    result.column_drive_low = (state_next.phase == PH_DRIVE_WAIT) ||
                              (state_next.phase == PH_SAMPLE);
    result.key_matrix       = state_next.reported;
  end

endmodule

// ===== rtl/core/key_matrix_column_scanner.sv =====
// Key matrix column scanner: one request per timer tick, one result per request.
// A request is registered in the request register and its step result in the result
// register; throughput is one request per cycle while the result is not stalled, set by
// the single update of the scan state register per tick.
// A stalled result holds the request register; both stages then hold their data.
// Reset (rst, synchronous) clears both stages, sets the phase to drive-and-wait-low,
// column and timer to zero, both matrices to zero and the settle timeout to 5000.
module key_matrix_column_scanner (
  input  logic                          clk,
  input  logic                          rst,
  kmcs_item_if.sink                     item,
  kmcs_result_if.source                 result,
  input  logic                          settle_timeout_we,
  input  logic [kmcs_pkg::TIMER_W-1:0]  settle_timeout_data
);
  import kmcs_pkg::*;

  logic               in_valid;
  item_t              in_data;
  logic               out_valid;
  result_t            out_data;
  scan_state_t        state;
  scan_state_t        state_next;
  result_t            step_result;
  logic [TIMER_W-1:0] settle_timeout;
  logic               advance;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  kmcs_step u_step (
    .state          (state),
    .item           (in_data),
    .settle_timeout (settle_timeout),
    .state_next     (state_next),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      settle_timeout <= SETTLE_RESET;
      state.phase    <= PH_DRIVE_WAIT;
      state.column   <= '0;
      state.timer    <= '0;
      state.work     <= '0;
      state.reported <= '0;
    end else begin
      if (settle_timeout_we) begin
        settle_timeout <= settle_timeout_data;
      end
      if (item.ready) begin
        in_valid <= item.valid;
      end
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_data.column_level <= item.column_level;
      in_data.row_levels   <= item.row_levels;
    end
    if (advance) begin
      out_data <= step_result;
    end
  end

  assign result.valid            = out_valid;
  assign result.column_select    = out_data.column_select;
  assign result.column_drive_low = out_data.column_drive_low;
  assign result.scan_done        = out_data.scan_done;
  assign result.matrix_changed   = out_data.matrix_changed;
  assign result.key_matrix       = out_data.key_matrix;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for key_matrix_column_scanner: ticks go in, one result per tick is
// checked against a cycle-accurate scan predictor under several settle timeouts and idling mixes.
// Depends on kmcs_pkg, kmcs_item_if, kmcs_result_if and the scanner RTL.
`timescale 1ns / 1ps

module tb;
  import kmcs_pkg::*;

  logic               clk;
  logic               rst;
  logic               settle_timeout_we;
  logic [TIMER_W-1:0] settle_timeout_data;

  kmcs_item_if   item_ch ();
  kmcs_result_if result_ch ();

  key_matrix_column_scanner u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .item                (item_ch),
    .result              (result_ch),
    .settle_timeout_we   (settle_timeout_we),
    .settle_timeout_data (settle_timeout_data)
  );

  item_t              tick_q[$];
  result_t            expected_q[$];
  scan_state_t        scan;
  scan_state_t        gen_scan;
  logic [TIMER_W-1:0] settle_cur;
  logic [TIMER_W-1:0] gen_timeout;
  logic [MATRIX_W-1:0] pressed;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 queued;
  int                 accepted;
  int                 failures;
  int                 scans_seen;
  int                 updates_seen;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic settle_ends(inout scan_state_t s, input logic cond,
                                       input logic [TIMER_W-1:0] timeout);
    if (cond || s.timer >= timeout) begin
      s.timer = '0;
      return 1'b1;
    end
    s.timer = s.timer + 1'b1;
    return 1'b0;
  endfunction

  function automatic result_t scan_tick(inout scan_state_t s, input logic [TIMER_W-1:0] timeout,
                                        input item_t it);
    result_t r;
    int      idx;
    r = '0;
    case (s.phase)
      PH_DRIVE_WAIT: begin
        if (settle_ends(s, !it.column_level, timeout)) s.phase = PH_SAMPLE;
      end
      PH_SAMPLE: begin
        for (int row = 0; row < ROWS; row++) begin
          idx = row * COLUMNS + int'(s.column);
          if (idx < MATRIX_W) s.work[idx] = ~it.row_levels[row];
        end
        s.timer = '0;
        s.phase = PH_WAIT_COL_HIGH;
      end
      PH_WAIT_COL_HIGH: begin
        if (settle_ends(s, it.column_level, timeout)) s.phase = PH_WAIT_GROUP1;
      end
      PH_WAIT_GROUP1: begin
        if (settle_ends(s, (it.row_levels & GROUP1_MASK) == GROUP1_MASK, timeout))
          s.phase = PH_WAIT_GROUP2;
      end
      PH_WAIT_GROUP2: begin
        if (settle_ends(s, (it.row_levels & GROUP2_MASK) == GROUP2_MASK, timeout)) begin
          s.phase = PH_DRIVE_WAIT;
          if (int'(s.column) + 1 >= COLUMNS) begin
            s.column = '0;
            r.scan_done = 1'b1;
            if (s.work != s.reported) begin
              s.reported = s.work;
              r.matrix_changed = 1'b1;
            end
          end else begin
            s.column = s.column + 1'b1;
          end
        end
      end
      default: begin
        s.phase = PH_DRIVE_WAIT;
        s.timer = '0;
      end
    endcase
    r.column_select    = SELECT_W'(s.column);
    r.column_drive_low = (s.phase == PH_DRIVE_WAIT || s.phase == PH_SAMPLE);
    r.key_matrix       = s.reported;
    return r;
  endfunction

  task automatic push_tick(input item_t it);
    result_t r;
    r = scan_tick(gen_scan, gen_timeout, it);
    if (r.scan_done && $urandom_range(1) == 1) begin
      case ($urandom_range(3))
        0: pressed = '0;
        1: pressed = '1;
        2: pressed = MATRIX_W'({$urandom, $urandom} & {$urandom, $urandom});
        default: pressed = MATRIX_W'({$urandom, $urandom});
      endcase
    end
    tick_q.push_back(it);
    queued++;
  endtask

  // Mostly ticks that let the scan progress, with random content and some noise mixed in.
  task automatic fill_ticks(input int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.column_level = 1'($urandom_range(1));
      it.row_levels   = ROW_W'($urandom_range(63));
      if ($urandom_range(99) < 85) begin
        case (gen_scan.phase)
          PH_DRIVE_WAIT:    it.column_level = ($urandom_range(3) == 0);
          PH_SAMPLE: begin
            for (int row = 0; row < ROWS; row++)
              it.row_levels[row] = ~pressed[row * COLUMNS + int'(gen_scan.column)];
          end
          PH_WAIT_COL_HIGH: it.column_level = ($urandom_range(3) != 0);
          PH_WAIT_GROUP1:   if ($urandom_range(3) != 0) it.row_levels |= GROUP1_MASK;
          PH_WAIT_GROUP2:   if ($urandom_range(3) != 0) it.row_levels |= GROUP2_MASK;
          default: ;
        endcase
      end
      push_tick(it);
    end
  endtask

  task automatic drain();
    while (accepted != queued || expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [TIMER_W-1:0] timeout, input int send_pct,
                           input int recv_pct, input int n);
    @(posedge clk);
    settle_timeout_we   <= 1'b1;
    settle_timeout_data <= timeout;
    @(posedge clk);
    settle_timeout_we <= 1'b0;
    settle_cur     = timeout;
    gen_timeout    = timeout;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    fill_ticks(n);
    drain();
  endtask

  task automatic check_field(input string name, input logic [MATRIX_W-1:0] want,
                             input logic [MATRIX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : driver
    item_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        nxt.column_level = item_ch.column_level;
        nxt.row_levels   = item_ch.row_levels;
        expected_q.push_back(scan_tick(scan, settle_cur, nxt));
        accepted++;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tick_q.pop_front();
          item_ch.valid        <= 1'b1;
          item_ch.column_level <= nxt.column_level;
          item_ch.row_levels   <= nxt.row_levels;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          failures++;
        end else begin
          want = expected_q.pop_front();
          check_field("column_select", MATRIX_W'(want.column_select),
                      MATRIX_W'(result_ch.column_select));
          check_field("column_drive_low", MATRIX_W'(want.column_drive_low),
                      MATRIX_W'(result_ch.column_drive_low));
          check_field("scan_done", MATRIX_W'(want.scan_done),
                      MATRIX_W'(result_ch.scan_done));
          check_field("matrix_changed", MATRIX_W'(want.matrix_changed),
                      MATRIX_W'(result_ch.matrix_changed));
          check_field("key_matrix", want.key_matrix, result_ch.key_matrix);
        end
        if (result_ch.scan_done === 1'b1) scans_seen++;
        if (result_ch.matrix_changed === 1'b1) updates_seen++;
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    item_t it;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.column_level = 1'b0;
    item_ch.row_levels   = '0;
    result_ch.ready      = 1'b0;
    settle_timeout_we    = 1'b0;
    settle_timeout_data  = '0;
    scan                 = '0;
    scan.phase           = PH_DRIVE_WAIT;
    gen_scan             = scan;
    settle_cur           = SETTLE_RESET;
    gen_timeout          = SETTLE_RESET;
    pressed              = MATRIX_W'({$urandom, $urandom});
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    queued               = 0;
    accepted             = 0;
    failures             = 0;
    scans_seen           = 0;
    updates_seen         = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // One column walked through every wait, with a failed and a passing check in each.
    it = '{column_level: 1'b1, row_levels: 6'h3F}; push_tick(it);
    it = '{column_level: 1'b0, row_levels: 6'h3F}; push_tick(it);
    it = '{column_level: 1'b1, row_levels: 6'h00}; push_tick(it);
    it = '{column_level: 1'b0, row_levels: 6'h3F}; push_tick(it);
    it = '{column_level: 1'b1, row_levels: 6'h38}; push_tick(it);
    it = '{column_level: 1'b1, row_levels: 6'h38}; push_tick(it);
    it = '{column_level: 1'b0, row_levels: 6'h07}; push_tick(it);
    it = '{column_level: 1'b1, row_levels: 6'h07}; push_tick(it);
    it = '{column_level: 1'b0, row_levels: 6'h3F}; push_tick(it);
    it = '{column_level: 1'b0, row_levels: 6'h2A}; push_tick(it);
    it = '{column_level: 1'b1, row_levels: 6'h15}; push_tick(it);
    fill_ticks(89);
    drain();

    run_phase(16'd0, 66, 0, 120);
    run_phase(16'hFFFF, 0, 66, 120);
    run_phase(16'd1, 27, 27, 120);
    run_phase(16'd3, 0, 0, 120);
    run_phase(TIMER_W'($urandom_range(20, 2)), 27, 27, 120);

    $display("Checked %0d ticks under six settle timeouts and four idling mixes.", accepted);
    $display("Saw %0d completed scans, %0d of them with a changed matrix.",
             scans_seen, updates_seen);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
